FILE: rtl/imptor_pkg.sv
// Shared constants and codes for the improper torsion energy block.
package imptor_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned TYPE_BITS_DEF     = 8;

  localparam int unsigned COUNT_W    = 7;
  localparam int unsigned INDEX_W    = 6;
  localparam int unsigned CODE_W     = 8;
  localparam int unsigned K_W        = 16;
  localparam int unsigned ANGLE_W    = 15;
  localparam int unsigned DIFF_W     = 16;
  localparam int unsigned MAG_W      = 14;
  localparam int unsigned SQ_W       = 2 * MAG_W;
  localparam int unsigned SQ_HALF_W  = MAG_W;
  localparam int unsigned CONST_W    = 18;
  localparam int unsigned KC_W       = K_W + CONST_W;
  localparam int unsigned PART_W     = KC_W + SQ_HALF_W;
  localparam int unsigned PROD_W     = KC_W + SQ_W;
  localparam int unsigned ANGLE_SQ_SHIFT = 41;
  localparam int unsigned TERM_W     = PROD_W - ANGLE_SQ_SHIFT;
  localparam int unsigned ENERGY_W   = 40;

  localparam int unsigned IN_DATA_W  = 72;
  localparam int unsigned OUT_DATA_W = 40;

  localparam logic [CONST_W-1:0] ANGLE_SQ_CONST = 18'd163540;
  localparam logic signed [DIFF_W-1:0] HALF_TURN = 16'sd11520;
  localparam logic signed [DIFF_W-1:0] FULL_TURN = 16'sd23040;

  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_EVAL = 1'b1
  } op_t;

endpackage

FILE: rtl/improper_torsion_energy.sv
// Improper torsion parameter table; a scan sums the energy terms of the first run of matches.
//
//   channel  direction  tdata (low bit up)                               tuser
//   s        in         entry_index, type_a, type_b, type_c, type_d,      operation
//                       wild_b, wild_c, force_const, angle, one pad bit
//   m        out        energy                                           matched
//   cfg      in         cfg_wdata = entry_count                          -
//
// A load transfer writes one table entry if its entry_index is below TABLE_ENTRIES.
// An evaluate transfer scans min(entry_count, TABLE_ENTRIES) entries, one a cycle, into a six
// stage match and multiply pipeline, which then drains; the summed energy loads as the result.
// s_tready rises in the same cycle that the result appears on m_tdata.
// A query that ends while the previous result still waits holds, with s_tready low, until
// that result is taken. Reset clears control state only; table entries are undefined.
module improper_torsion_energy #(
  parameter int unsigned TABLE_ENTRIES = imptor_pkg::TABLE_ENTRIES_DEF,
  parameter int unsigned TYPE_BITS     = imptor_pkg::TYPE_BITS_DEF
) (
  input  logic                                 clk,
  input  logic                                 rst,
  input  logic                                 cfg_we,
  input  logic [imptor_pkg::COUNT_W-1:0]       cfg_wdata,
  input  logic                                 s_tvalid,
  output logic                                 s_tready,
  // entry_index, type_a, type_b, type_c, type_d, wild_b, wild_c, force_const, angle, pad
  input  logic [imptor_pkg::IN_DATA_W-1:0]     s_tdata,
  // operation
  input  logic                                 s_tuser,
  output logic                                 m_tvalid,
  input  logic                                 m_tready,
  // energy
  output logic [imptor_pkg::OUT_DATA_W-1:0]    m_tdata,
  // matched
  output logic                                 m_tuser
);

  localparam int unsigned IDX_W = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned NW    = (IDX_W + 1 > imptor_pkg::COUNT_W) ? IDX_W + 1
                                                                    : imptor_pkg::COUNT_W;
  localparam logic [NW-1:0] LIMIT_MAX = NW'(TABLE_ENTRIES);

  typedef struct packed {
    logic [TYPE_BITS-1:0]                   ta;
    logic [TYPE_BITS-1:0]                   tb;
    logic [TYPE_BITS-1:0]                   tc;
    logic [TYPE_BITS-1:0]                   td;
    logic                                   wb;
    logic                                   wc;
    logic [imptor_pkg::K_W-1:0]             k;
    logic signed [imptor_pkg::ANGLE_W-1:0]  ang;
  } entry_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

  state_t state;

  logic [imptor_pkg::INDEX_W-1:0]        in_index;
  logic [imptor_pkg::CODE_W-1:0]         in_ta, in_tb, in_tc, in_td;
  logic                                  in_wb, in_wc;
  logic [imptor_pkg::K_W-1:0]            in_k;
  logic signed [imptor_pkg::ANGLE_W-1:0] in_angle;

  assign in_index = s_tdata[5:0];
  assign in_ta    = s_tdata[13:6];
  assign in_tb    = s_tdata[21:14];
  assign in_tc    = s_tdata[29:22];
  assign in_td    = s_tdata[37:30];
  assign in_wb    = s_tdata[38];
  assign in_wc    = s_tdata[39];
  assign in_k     = s_tdata[55:40];
  assign in_angle = s_tdata[70:56];

  logic accept, is_eval, load_we;
  entry_t wr_entry;

  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign is_eval  = accept && (imptor_pkg::op_t'(s_tuser) == imptor_pkg::OP_EVAL);
  assign load_we  = accept && (imptor_pkg::op_t'(s_tuser) == imptor_pkg::OP_LOAD) &&
                    (NW'(in_index) < LIMIT_MAX);

  always_comb begin
    wr_entry.ta  = TYPE_BITS'(in_ta);
    wr_entry.tb  = TYPE_BITS'(in_tb);
    wr_entry.tc  = TYPE_BITS'(in_tc);
    wr_entry.td  = TYPE_BITS'(in_td);
    wr_entry.wb  = in_wb;
    wr_entry.wc  = in_wc;
    wr_entry.k   = in_k;
    wr_entry.ang = in_angle;
  end

  logic [imptor_pkg::COUNT_W-1:0] entry_count;

  always_ff @(posedge clk) begin
    if (rst) begin
      entry_count <= '0;
    end else if (cfg_we) begin
      entry_count <= cfg_wdata;
    end
  end

  // Query registers and scan counter.
  logic [TYPE_BITS-1:0]                  qa, qb, qc, qd;
  logic signed [imptor_pkg::ANGLE_W-1:0] q_psi;
  logic [NW-1:0]                         j, limit;
  logic                                  issue;

  assign issue = (state == ST_SCAN) && (j < limit);

  always_ff @(posedge clk) begin
    if (is_eval) begin
      qa    <= TYPE_BITS'(in_ta);
      qb    <= TYPE_BITS'(in_tb);
      qc    <= TYPE_BITS'(in_tc);
      qd    <= TYPE_BITS'(in_td);
      q_psi <= in_angle;
      limit <= (NW'(entry_count) > LIMIT_MAX) ? LIMIT_MAX : NW'(entry_count);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      j <= '0;
    end else if (is_eval) begin
      j <= '0;
    end else if (issue) begin
      j <= j + 1'b1;
    end
  end

  // Table memory.
  entry_t mem [TABLE_ENTRIES];
  entry_t rd;

  always_ff @(posedge clk) begin
    if (load_we) begin
      mem[IDX_W'(in_index)] <= wr_entry;
    end
    if (issue) begin
      rd <= mem[j[IDX_W-1:0]];
    end
  end

  logic [6:1] vld;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      vld <= {vld[5:1], issue};
    end
  end

  // Stage 1: match and raw angle difference.
  logic fwd, rev, fits, hit_now;
  logic any_hit, stopped;

  assign fwd = (rd.ta == qa) && (rd.wb || rd.tb == qb) &&
               (rd.wc || rd.tc == qc) && (rd.td == qd);
  assign rev = (rd.ta == qd) && (rd.wb || rd.tb == qc) &&
               (rd.wc || rd.tc == qb) && (rd.td == qa);
  assign fits    = fwd || rev;
  assign hit_now = vld[1] && fits && !stopped;

  always_ff @(posedge clk) begin
    if (rst) begin
      any_hit <= 1'b0;
      stopped <= 1'b0;
    end else if (is_eval) begin
      any_hit <= 1'b0;
      stopped <= 1'b0;
    end else if (vld[1]) begin
      if (fits && !stopped) begin
        any_hit <= 1'b1;
      end else if (!fits && any_hit) begin
        stopped <= 1'b1;
      end
    end
  end

  logic                                   h1, h2, h3, h4, h5, h6;
  logic signed [imptor_pkg::DIFF_W-1:0]   d1, d2;
  logic [imptor_pkg::K_W-1:0]             k1, k2;
  logic [imptor_pkg::MAG_W-1:0]           m3;
  logic [imptor_pkg::KC_W-1:0]            kc3, kc4;
  logic [imptor_pkg::SQ_W-1:0]            sq4;
  logic [imptor_pkg::PART_W-1:0]          plo, phi;
  logic [imptor_pkg::PROD_W-1:0]          prod;
  logic [imptor_pkg::TERM_W-1:0]          term6;
  logic [imptor_pkg::ENERGY_W:0]          sum_ext;
  logic [imptor_pkg::ENERGY_W-1:0]        sum;

  assign prod = {{(imptor_pkg::PROD_W - imptor_pkg::PART_W){1'b0}}, plo} +
                {phi, {imptor_pkg::SQ_HALF_W{1'b0}}};
  assign sum_ext = {1'b0, sum} +
                   {{(imptor_pkg::ENERGY_W + 1 - imptor_pkg::TERM_W){1'b0}}, term6};

  always_ff @(posedge clk) begin
    h1 <= hit_now;
    d1 <= {q_psi[imptor_pkg::ANGLE_W-1], q_psi} - {rd.ang[imptor_pkg::ANGLE_W-1], rd.ang};
    k1 <= rd.k;

    h2 <= h1;
    k2 <= k1;
    if (d1 < -imptor_pkg::HALF_TURN) begin
      d2 <= d1 + imptor_pkg::FULL_TURN;
    end else if (d1 > imptor_pkg::HALF_TURN) begin
      d2 <= d1 - imptor_pkg::FULL_TURN;
    end else begin
      d2 <= d1;
    end

    h3  <= h2;
    m3  <= d2[imptor_pkg::DIFF_W-1] ? imptor_pkg::MAG_W'(-d2) : imptor_pkg::MAG_W'(d2);
    kc3 <= {{imptor_pkg::CONST_W{1'b0}}, k2} *
           {{imptor_pkg::K_W{1'b0}}, imptor_pkg::ANGLE_SQ_CONST};

    h4  <= h3;
    kc4 <= kc3;
    sq4 <= {{imptor_pkg::MAG_W{1'b0}}, m3} * {{imptor_pkg::MAG_W{1'b0}}, m3};

    h5  <= h4;
    plo <= {{imptor_pkg::SQ_HALF_W{1'b0}}, kc4} *
           {{imptor_pkg::KC_W{1'b0}}, sq4[imptor_pkg::SQ_HALF_W-1:0]};
    phi <= {{imptor_pkg::SQ_HALF_W{1'b0}}, kc4} *
           {{imptor_pkg::KC_W{1'b0}}, sq4[imptor_pkg::SQ_W-1:imptor_pkg::SQ_HALF_W]};

    h6    <= h5;
    term6 <= prod[imptor_pkg::PROD_W-1:imptor_pkg::ANGLE_SQ_SHIFT];

    if (is_eval) begin
      sum <= '0;
    end else if (h6) begin
      sum <= sum_ext[imptor_pkg::ENERGY_W] ? '1 : sum_ext[imptor_pkg::ENERGY_W-1:0];
    end
  end

  logic out_load;

  assign out_load = (state == ST_DONE) && (!m_tvalid || m_tready);

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (is_eval) begin
            state <= ST_SCAN;
          end
        end
        ST_SCAN: begin
          if (j == limit && vld == '0) begin
            state <= ST_DONE;
          end
        end
        ST_DONE: begin
          if (out_load) begin
            m_tdata  <= sum;
            m_tuser  <= any_hit;
            state    <= ST_IDLE;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

FILE: rtl/imptor_chk.sv
// Port-level checker for the improper torsion energy block, with its bind.
module imptor_chk (
  input logic                              clk,
  input logic                              rst,
  input logic                              cfg_we,
  input logic [imptor_pkg::COUNT_W-1:0]    cfg_wdata,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic [imptor_pkg::IN_DATA_W-1:0]  s_tdata,
  input logic                              s_tuser,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [imptor_pkg::OUT_DATA_W-1:0] m_tdata,
  input logic                              m_tuser
);

  logic eval_xfer, load_xfer;

  assign eval_xfer = s_tvalid && s_tready && (s_tuser == imptor_pkg::OP_EVAL);
  assign load_xfer = s_tvalid && s_tready && (s_tuser == imptor_pkg::OP_LOAD);

  a_reset_quiet: assert property (@(posedge clk) rst |=> !m_tvalid && s_tready)
    else $error("block not idle after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tuser))
    else $error("stalled result changed");

  a_load_silent: assert property (@(posedge clk) disable iff (rst)
    load_xfer && !m_tvalid |=> !m_tvalid)
    else $error("load transfer produced a result");

  a_eval_busy: assert property (@(posedge clk) disable iff (rst)
    eval_xfer |=> !s_tready)
    else $error("input still ready after an evaluate transfer");

  a_nomatch_zero: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tuser |-> m_tdata == '0)
    else $error("nonzero energy without a match");

endmodule

bind improper_torsion_energy imptor_chk u_imptor_chk (.*);
